### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/gtg_pkg.sv
package gtg_pkg;

    localparam int POS_W   = 32;   // Q16.16 positions and velocities
    localparam int Q_W     = 16;   // Q1.14 quaternion parts
    localparam int GAIN_W  = 16;   // Q8.8 gains
    localparam int TOL_W   = 31;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int GUARD   = 8;
    localparam int XW      = 45;   // position CORDIC x/y
    localparam int QXW     = 28;   // quaternion CORDIC x/y
    localparam int ZW      = 20;   // Q.16 angle accumulator
    localparam int EW      = 22;   // heading error before wrap
    localparam int E13W    = 20;   // heading error in Q3.13
    localparam int DISTW   = 36;   // distance after scaling
    localparam int KW      = 20;

    localparam logic signed [ZW-1:0] PI_Q16     = ZW'(205887);
    localparam logic signed [EW-1:0] PI_E       = EW'(205887);
    localparam logic signed [EW-1:0] TWO_PI_E   = EW'(411775);
    localparam logic [KW-1:0]        INV_K_Q20  = KW'(636752);

    typedef enum logic [1:0] {
        REG_LINEAR_GAIN  = 2'd0,
        REG_ANGULAR_GAIN = 2'd1,
        REG_ARRIVE_TOL   = 2'd2,
        REG_NONE         = 2'd3
    } reg_idx_t;

    // atan(2^-i) in Q.16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = ZW'(51472);
            1:       r = ZW'(30386);
            2:       r = ZW'(16055);
            3:       r = ZW'(8150);
            4:       r = ZW'(4091);
            5:       r = ZW'(2047);
            6:       r = ZW'(1024);
            7:       r = ZW'(512);
            8:       r = ZW'(256);
            9:       r = ZW'(128);
            10:      r = ZW'(64);
            11:      r = ZW'(32);
            12:      r = ZW'(16);
            13:      r = ZW'(8);
            14:      r = ZW'(4);
            15:      r = ZW'(2);
            16:      r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // one wrap step toward [-pi, pi]
    function automatic logic signed [EW-1:0] wrap_once(input logic signed [EW-1:0] e);
        logic signed [EW-1:0] r;
        if (e > PI_E) begin
            r = e - TWO_PI_E;
        end else if (e < -PI_E) begin
            r = e + TWO_PI_E;
        end else begin
            r = e;
        end
        return r;
    endfunction

endpackage

### sv/go_to_goal_velocity_core.sv
// Channel   Handshake            Payload
// s_ pose   s_valid / s_ready    s_cur_x s_cur_y s_cur_qz s_cur_qw s_goal_x s_goal_y
// m_ cmd    m_valid / m_ready    m_linear_vel m_angular_vel m_arrived
// APB cfg   psel/penable/pready  paddr pwrite pwdata prdata
//
// One pose transfer per cycle unless m_ready stalls the pipe. Stages: one
// prerotation stage, one stage per CORDIC micro-rotation (both CORDICs side
// by side), then five stages for scaling, wrap, compare, gain multiply and
// round/saturate. The whole pipe advances together; a stall on m_ready
// freezes every stage, and s_ready drops with it. Reset (synchronous, low)
// clears the valid bits and restores the gain and tolerance registers.
module go_to_goal_velocity_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [gtg_pkg::POS_W-1:0]   s_cur_x,
    input  logic signed [gtg_pkg::POS_W-1:0]   s_cur_y,
    input  logic signed [gtg_pkg::Q_W-1:0]     s_cur_qz,
    input  logic signed [gtg_pkg::Q_W-1:0]     s_cur_qw,
    input  logic signed [gtg_pkg::POS_W-1:0]   s_goal_x,
    input  logic signed [gtg_pkg::POS_W-1:0]   s_goal_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [gtg_pkg::POS_W-1:0]   m_linear_vel,
    output logic signed [gtg_pkg::POS_W-1:0]   m_angular_vel,
    output logic                               m_arrived,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gtg_pkg::APB_AW-1:0]         paddr,
    input  logic [gtg_pkg::APB_DW-1:0]         pwdata,
    output logic [gtg_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import gtg_pkg::*;

    localparam int N = CORDIC_STEPS;

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0] lin_gain_reg, ang_gain_reg;
    logic [TOL_W-1:0]  tol_reg;
    reg_idx_t          addr_idx;

    assign pready   = 1'b1;
    assign addr_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_gain_reg <= GAIN_W'(26);
            ang_gain_reg <= GAIN_W'(256);
            tol_reg      <= TOL_W'(6554);
        end else if (psel && penable && pwrite) begin
            case (addr_idx)
                REG_LINEAR_GAIN:  lin_gain_reg <= pwdata[GAIN_W-1:0];
                REG_ANGULAR_GAIN: ang_gain_reg <= pwdata[GAIN_W-1:0];
                REG_ARRIVE_TOL:   tol_reg      <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (addr_idx)
            REG_LINEAR_GAIN:  prdata = APB_DW'(lin_gain_reg);
            REG_ANGULAR_GAIN: prdata = APB_DW'(ang_gain_reg);
            REG_ARRIVE_TOL:   prdata = APB_DW'(tol_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    // Every stage moves when the output slot is free or being drained.
    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // ---------------- CORDIC stage arrays ----------------
    logic                  vld_reg  [0:N];
    logic signed [XW-1:0]  px_reg   [0:N];
    logic signed [XW-1:0]  py_reg   [0:N];
    logic signed [ZW-1:0]  pz_reg   [0:N];
    logic                  pzero_reg[0:N];
    logic signed [QXW-1:0] qx_reg   [0:N];
    logic signed [QXW-1:0] qy_reg   [0:N];
    logic signed [ZW-1:0]  qz_reg   [0:N];
    logic                  qzero_reg[0:N];

    // prerotation: differences, guard bits, left half plane turned by 180 degrees
    logic signed [POS_W:0]  dx, dy;
    logic signed [XW-1:0]   dxg, dyg;
    logic signed [QXW-1:0]  qwg, qzg;
    logic signed [XW-1:0]   px_next, py_next;
    logic signed [ZW-1:0]   pz_next, qz_next;
    logic signed [QXW-1:0]  qx_next, qy_next;

    always_comb begin
        dx  = (POS_W+1)'(s_goal_x) - (POS_W+1)'(s_cur_x);
        dy  = (POS_W+1)'(s_goal_y) - (POS_W+1)'(s_cur_y);
        dxg = XW'(dx) <<< GUARD;
        dyg = XW'(dy) <<< GUARD;
        qwg = QXW'(s_cur_qw) <<< GUARD;
        qzg = QXW'(s_cur_qz) <<< GUARD;
        if (dxg[XW-1]) begin
            px_next = -dxg;
            py_next = -dyg;
            pz_next = dyg[XW-1] ? -PI_Q16 : PI_Q16;
        end else begin
            px_next = dxg;
            py_next = dyg;
            pz_next = '0;
        end
        if (qwg[QXW-1]) begin
            qx_next = -qwg;
            qy_next = -qzg;
            qz_next = qzg[QXW-1] ? -PI_Q16 : PI_Q16;
        end else begin
            qx_next = qwg;
            qy_next = qzg;
            qz_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg[0]    <= px_next;
            py_reg[0]    <= py_next;
            pz_reg[0]    <= pz_next;
            pzero_reg[0] <= (dx == '0) && (dy == '0);
            qx_reg[0]    <= qx_next;
            qy_reg[0]    <= qy_next;
            qz_reg[0]    <= qz_next;
            qzero_reg[0] <= (s_cur_qw == '0) && (s_cur_qz == '0);
        end
    end

    // one micro-rotation per stage for both vectors
    for (genvar k = 0; k < N; k++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = atan_q16(k);
        logic signed [XW-1:0]  pxs, pys;
        logic signed [QXW-1:0] qxs, qys;

        assign pxs = px_reg[k] >>> k;
        assign pys = py_reg[k] >>> k;
        assign qxs = qx_reg[k] >>> k;
        assign qys = qy_reg[k] >>> k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (py_reg[k][XW-1]) begin
                    px_reg[k+1] <= px_reg[k] - pys;
                    py_reg[k+1] <= py_reg[k] + pxs;
                    pz_reg[k+1] <= pz_reg[k] - ATAN;
                end else begin
                    px_reg[k+1] <= px_reg[k] + pys;
                    py_reg[k+1] <= py_reg[k] - pxs;
                    pz_reg[k+1] <= pz_reg[k] + ATAN;
                end
                if (qy_reg[k][QXW-1]) begin
                    qx_reg[k+1] <= qx_reg[k] - qys;
                    qy_reg[k+1] <= qy_reg[k] + qxs;
                    qz_reg[k+1] <= qz_reg[k] - ATAN;
                end else begin
                    qx_reg[k+1] <= qx_reg[k] + qys;
                    qy_reg[k+1] <= qy_reg[k] - qxs;
                    qz_reg[k+1] <= qz_reg[k] + ATAN;
                end
                pzero_reg[k+1] <= pzero_reg[k];
                qzero_reg[k+1] <= qzero_reg[k];
            end
        end
    end

    // ---------------- post processing ----------------
    logic [4:0] pv_reg;

    // P1: scale magnitude by 1/K, form raw heading error
    logic [XW+KW-2:0]     prod1_reg;
    logic signed [EW-1:0] err1_reg;
    logic signed [ZW-1:0] bear, hyaw;

    assign bear = pzero_reg[N] ? '0 : pz_reg[N];
    assign hyaw = qzero_reg[N] ? '0 : qz_reg[N];

    // P2: round distance, first wrap
    logic [DISTW-1:0]     dist2_reg;
    logic signed [EW-1:0] err2_reg;
    logic [XW+KW-2:0]     rnd1;
    assign rnd1 = prod1_reg + (XW+KW-1)'(64'd1 << 27);

    // P3: arrival test, second wrap, round to Q3.13
    logic                   arr3_reg;
    logic [DISTW-1:0]       dist3_reg;
    logic signed [E13W-1:0] e13_3_reg;
    logic signed [EW-1:0]   e_wr;
    assign e_wr = wrap_once(err2_reg) + EW'(4);

    // P4: gain multiplies
    logic                            arr4_reg;
    logic [GAIN_W+DISTW-1:0]         lprod4_reg;
    logic signed [GAIN_W+E13W:0]     aprod4_reg;

    // P5: round and saturate into the output register
    logic [GAIN_W+DISTW-1:0]     lrnd;
    logic signed [GAIN_W+E13W:0] arnd;
    logic [GAIN_W+DISTW-9:0]     lsh;
    logic signed [GAIN_W+E13W-5:0] ash;
    logic signed [POS_W-1:0]     lin_next, ang_next;

    always_comb begin
        lrnd = lprod4_reg + (GAIN_W+DISTW)'(128);
        arnd = aprod4_reg + (GAIN_W+E13W+1)'(16);
        lsh  = lrnd[GAIN_W+DISTW-1:8];
        ash  = arnd[GAIN_W+E13W:5];
        if (lsh > (GAIN_W+DISTW-8)'(32'h7FFF_FFFF)) begin
            lin_next = 32'sh7FFF_FFFF;
        end else begin
            lin_next = lsh[POS_W-1:0];
        end
        if (ash > (GAIN_W+E13W-4)'(32'sh7FFF_FFFF)) begin
            ang_next = 32'sh7FFF_FFFF;
        end else if (ash < -(GAIN_W+E13W-4)'(33'sh0_8000_0000)) begin
            ang_next = -32'sh7FFF_FFFF - 32'sd1;
        end else begin
            ang_next = ash[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg  <= '0;
        end else if (ce) begin
            pv_reg  <= {pv_reg[3:0], vld_reg[N]};
        end
    end

    assign m_valid = pv_reg[4];

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod1_reg  <= px_reg[N][XW-2:0] * INV_K_Q20;
            err1_reg   <= EW'(bear) - (EW'(hyaw) <<< 1);
            dist2_reg  <= DISTW'(rnd1[XW+KW-2:28]);
            err2_reg   <= wrap_once(err1_reg);
            arr3_reg   <= dist2_reg < DISTW'(tol_reg);
            dist3_reg  <= dist2_reg;
            e13_3_reg  <= E13W'(e_wr >>> 3);
            arr4_reg   <= arr3_reg;
            lprod4_reg <= lin_gain_reg * dist3_reg;
            aprod4_reg <= $signed({1'b0, ang_gain_reg}) * e13_3_reg;
            m_arrived  <= arr4_reg;
            m_linear_vel  <= arr4_reg ? '0 : lin_next;
            m_angular_vel <= arr4_reg ? '0 : ang_next;
        end
    end

endmodule

### sv/gtg_checker.sv
`include "assert_macros.svh"

module gtg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_linear_vel,
    input logic [31:0] m_angular_vel,
    input logic        m_arrived
);
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_hold_lin, aclk, aresetn, m_valid && !m_ready, $stable(m_linear_vel))
    `ASSERT_IMPL(a_arrived_zero, aclk, aresetn, m_valid && m_arrived, (m_linear_vel == 32'd0) && (m_angular_vel == 32'd0))
    `ASSERT_IMPL(a_lin_nonneg, aclk, aresetn, m_valid, !m_linear_vel[31])
    `ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid || m_ready, s_ready)
endmodule

bind go_to_goal_velocity_core gtg_checker u_gtg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_linear_vel  (m_linear_vel),
    .m_angular_vel (m_angular_vel),
    .m_arrived     (m_arrived)
);
